### rtl/core/rsm_gic_pkg.sv
`timescale 1ns / 1ps

package rsm_gic_pkg;

  localparam int NUM_COEF    = 36;
  localparam int COORD_W     = 32;
  localparam int COEF_W      = 48;
  localparam int DELTA_W     = 40;
  localparam int INDEX_W     = 6;
  localparam int GSUM_W      = COEF_W + 1;
  localparam int GACC_W      = 84;
  localparam int IACC_W      = 118;
  localparam int LIN_W       = 82;
  localparam int GROUND_RND  = 32;
  localparam int IMAGE_RND   = 48;
  localparam int SAT_IN_W    = 128;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic signed [COEF_W-1:0]    coef_t;
  typedef logic signed [DELTA_W-1:0]   delta_t;
  typedef logic        [INDEX_W-1:0]   index_t;
  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_array_t;

  typedef struct packed {
    logic   en;
    index_t index;
    coef_t  value;
  } coef_wr_t;

  typedef struct packed {
    logic   flag;
    delta_t value;
  } sat_delta_t;

  typedef struct packed {
    logic   flag;
    coord_t value;
  } sat_coord_t;

  function automatic sat_delta_t sat_delta(input logic signed [SAT_IN_W-1:0] v);
    sat_delta_t r;
    r.flag  = (v[SAT_IN_W-1:DELTA_W-1] != '0) && (v[SAT_IN_W-1:DELTA_W-1] != '1);
    r.value = v[DELTA_W-1:0];
    if (r.flag) begin
      r.value = v[SAT_IN_W-1] ? {1'b1, {(DELTA_W-1){1'b0}}} : {1'b0, {(DELTA_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic sat_coord_t sat_coord(input logic signed [DELTA_W:0] v);
    sat_coord_t r;
    r.flag  = (v[DELTA_W:COORD_W-1] != '0) && (v[DELTA_W:COORD_W-1] != '1);
    r.value = v[COORD_W-1:0];
    if (r.flag) begin
      r.value = v[DELTA_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### rtl/core/rsm_gic_if.sv
`timescale 1ns / 1ps

interface rsm_gic_item_if;
  import rsm_gic_pkg::*;
  logic   valid;
  logic   ready;
  logic   op;
  index_t coef_index;
  coef_t  coef_value;
  coord_t x_coord;
  coord_t y_coord;
  coord_t z_coord;
  modport source (output valid, op, coef_index, coef_value, x_coord, y_coord, z_coord,
                  input ready);
  modport sink (input valid, op, coef_index, coef_value, x_coord, y_coord, z_coord,
                output ready);
endinterface

interface rsm_gic_result_if;
  import rsm_gic_pkg::*;
  logic   valid;
  logic   ready;
  delta_t x_delta;
  delta_t y_delta;
  delta_t z_delta;
  coord_t adj_x;
  coord_t adj_y;
  coord_t adj_z;
  delta_t line_delta;
  delta_t sample_delta;
  logic   saturated;
  modport source (output valid, x_delta, y_delta, z_delta, adj_x, adj_y, adj_z,
                  line_delta, sample_delta, saturated, input ready);
  modport sink (input valid, x_delta, y_delta, z_delta, adj_x, adj_y, adj_z,
                line_delta, sample_delta, saturated, output ready);
endinterface

### rtl/core/rsm_ground_image_correction.sv
`timescale 1ns / 1ps

// Channel  Interface            Role    Moves
// item     rsm_gic_item_if      sink    one load or evaluate request
// result   rsm_gic_result_if    source  corrections for one evaluate request
//
// A request is taken every cycle in which the result register is empty or being read.
// An evaluate request passes through a six-stage multiplier pipeline (s1 to s6)
// before its result appears; a load request writes the table at once, no result.
// Reset clears the coefficient table and all stage valid bits.
// A stall on result freezes every stage, so nothing is lost or repeated.

module rsm_ground_image_correction (
  input logic        clk,
  input logic        rst,
  rsm_gic_item_if.sink     item,
  rsm_gic_result_if.source result
);
  import rsm_gic_pkg::*;

  typedef logic signed [GSUM_W-1:0]  gsum_t;
  typedef logic signed [GACC_W-1:0]  gacc_t;
  typedef logic signed [IACC_W-1:0]  iacc_t;
  typedef logic signed [LIN_W-1:0]   lin_t;
  typedef logic signed [2*COORD_W-1:0] quad_t;
  typedef logic signed [57:0]        part_t;

  localparam gacc_t GACC_HALF = gacc_t'(1) <<< (GROUND_RND - 1);
  localparam iacc_t IACC_HALF = iacc_t'(1) <<< (IMAGE_RND - 1);

  coef_array_t coefs;
  coef_wr_t    wr;
  logic        en;

  logic s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld;

  coord_t s1_v [3];
  gsum_t  s1_gc [3][3];
  coef_t  s1_goff [3];
  coef_t  s1_ic [2][10];

  coord_t s2_v [3];
  coef_t  s2_goff [3];
  quad_t  s2_q [6];
  part_t  s2_glo [3][3];
  part_t  s2_ghi [3][3];
  part_t  s2_llo [2][3];
  part_t  s2_lhi [2][3];
  coef_t  s2_ic0 [2];
  coef_t  s2_icq [2][6];

  coord_t s3_v [3];
  gacc_t  s3_gacc [3];
  lin_t   s3_lin [2];
  part_t  s3_qp [2][6][4];
  coef_t  s3_ic0 [2];

  coord_t s4_v [3];
  delta_t s4_d [3];
  logic   s4_flag;
  lin_t   s4_lin [2];
  iacc_t  s4_term [2][6];
  coef_t  s4_ic0 [2];

  delta_t s5_d [3];
  coord_t s5_adj [3];
  logic   s5_flag;
  iacc_t  s5_iacc [2];

  delta_t s6_d [3];
  coord_t s6_adj [3];
  delta_t s6_img [2];
  logic   s6_flag;

  gsum_t      gc_next [3][3];
  gacc_t      gacc_next [3];
  lin_t       lin_next [2];
  iacc_t      term_next [2][6];
  delta_t     d_next [3];
  logic       flag4_next;
  coord_t     adj_next [3];
  logic       flag5_next;
  iacc_t      iacc_next [2];
  delta_t     img_next [2];
  logic       flag6_next;
  sat_delta_t sd;
  sat_delta_t sd_img;
  sat_coord_t sc;
  gacc_t      gr;
  iacc_t      ir;

  assign en          = !s6_vld || result.ready;
  assign item.ready  = en;
  assign wr.en       = item.valid && en && item.op == OP_LOAD;
  assign wr.index    = item.coef_index;
  assign wr.value    = item.coef_value;

  rsm_gic_coef_table u_table (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .coefs (coefs)
  );

  function automatic gsum_t cadd(input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b,
                                 input logic sub);
    gsum_t r;
    r = sub ? gsum_t'($signed(a)) - gsum_t'($signed(b))
            : gsum_t'($signed(a)) + gsum_t'($signed(b));
    return r;
  endfunction

  always_comb begin
    gc_next[0][0] = cadd(coefs[26], coefs[27], 1'b0);
    gc_next[0][1] = cadd(coefs[25], coefs[28], 1'b0);
    gc_next[0][2] = cadd(coefs[29], coefs[24], 1'b1);
    gc_next[1][0] = cadd(coefs[30], coefs[25], 1'b1);
    gc_next[1][1] = cadd(coefs[26], coefs[31], 1'b0);
    gc_next[1][2] = cadd(coefs[23], coefs[32], 1'b0);
    gc_next[2][0] = cadd(coefs[24], coefs[33], 1'b0);
    gc_next[2][1] = cadd(coefs[34], coefs[23], 1'b1);
    gc_next[2][2] = cadd(coefs[26], coefs[35], 1'b0);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gacc_next[k] = gacc_t'(s2_goff[k]) <<< 16;
      for (int j = 0; j < 3; j++) begin
        gacc_next[k] = gacc_next[k] + (gacc_t'(s2_ghi[k][j]) <<< 24) + gacc_t'(s2_glo[k][j]);
      end
    end
    for (int m = 0; m < 2; m++) begin
      lin_next[m] = '0;
      for (int j = 0; j < 3; j++) begin
        lin_next[m] = lin_next[m] + (lin_t'(s2_lhi[m][j]) <<< 24) + lin_t'(s2_llo[m][j]);
      end
    end
  end

  always_comb begin
    flag4_next = 1'b0;
    gr = '0;
    sd = '0;
    for (int k = 0; k < 3; k++) begin
      gr = (s3_gacc[k] + GACC_HALF) >>> GROUND_RND;
      sd = sat_delta(SAT_IN_W'(gr));
      d_next[k] = sd.value;
      flag4_next = flag4_next | sd.flag;
    end
    for (int m = 0; m < 2; m++) begin
      for (int t = 0; t < 6; t++) begin
        term_next[m][t] = (iacc_t'(s3_qp[m][t][3]) <<< 56) + (iacc_t'(s3_qp[m][t][2]) <<< 32)
                        + (iacc_t'(s3_qp[m][t][1]) <<< 24) + iacc_t'(s3_qp[m][t][0]);
      end
    end
  end

  always_comb begin
    flag5_next = s4_flag;
    sc = '0;
    for (int k = 0; k < 3; k++) begin
      sc = sat_coord((DELTA_W + 1)'(s4_v[k]) + (DELTA_W + 1)'(s4_d[k]));
      adj_next[k] = sc.value;
      flag5_next = flag5_next | sc.flag;
    end
    for (int m = 0; m < 2; m++) begin
      iacc_next[m] = (iacc_t'(s4_ic0[m]) <<< 32) + (iacc_t'(s4_lin[m]) <<< 16);
      for (int t = 0; t < 6; t++) begin
        iacc_next[m] = iacc_next[m] + s4_term[m][t];
      end
    end
  end

  always_comb begin
    flag6_next = s5_flag;
    ir = '0;
    sd_img = '0;
    for (int m = 0; m < 2; m++) begin
      ir = (s5_iacc[m] + IACC_HALF) >>> IMAGE_RND;
      sd_img = sat_delta(SAT_IN_W'(ir));
      img_next[m] = sd_img.value;
      flag6_next = flag6_next | sd_img.flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= item.valid && item.op == OP_EVAL;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v[0] <= item.x_coord;
      s1_v[1] <= item.y_coord;
      s1_v[2] <= item.z_coord;
      s1_gc   <= gc_next;
      for (int k = 0; k < 3; k++) begin
        s1_goff[k] <= coefs[20 + k];
      end
      for (int m = 0; m < 2; m++) begin
        for (int i = 0; i < 10; i++) begin
          s1_ic[m][i] <= coefs[10 * m + i];
        end
      end

      s2_v    <= s1_v;
      s2_goff <= s1_goff;
      s2_q[0] <= s1_v[0] * s1_v[0];
      s2_q[1] <= s1_v[0] * s1_v[1];
      s2_q[2] <= s1_v[0] * s1_v[2];
      s2_q[3] <= s1_v[1] * s1_v[1];
      s2_q[4] <= s1_v[1] * s1_v[2];
      s2_q[5] <= s1_v[2] * s1_v[2];
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          s2_glo[k][j] <= $signed({1'b0, s1_gc[k][j][23:0]}) * s1_v[j];
          s2_ghi[k][j] <= $signed(s1_gc[k][j][GSUM_W-1:24]) * s1_v[j];
        end
      end
      for (int m = 0; m < 2; m++) begin
        for (int j = 0; j < 3; j++) begin
          s2_llo[m][j] <= $signed({1'b0, s1_ic[m][1 + j][23:0]}) * s1_v[j];
          s2_lhi[m][j] <= $signed(s1_ic[m][1 + j][COEF_W-1:24]) * s1_v[j];
        end
        s2_ic0[m] <= s1_ic[m][0];
        for (int t = 0; t < 6; t++) begin
          s2_icq[m][t] <= s1_ic[m][4 + t];
        end
      end

      s3_v    <= s2_v;
      s3_gacc <= gacc_next;
      s3_lin  <= lin_next;
      s3_ic0  <= s2_ic0;
      for (int m = 0; m < 2; m++) begin
        for (int t = 0; t < 6; t++) begin
          s3_qp[m][t][0] <= $signed({1'b0, s2_q[t][31:0]}) * $signed({1'b0, s2_icq[m][t][23:0]});
          s3_qp[m][t][1] <= $signed({1'b0, s2_q[t][31:0]}) * $signed(s2_icq[m][t][COEF_W-1:24]);
          s3_qp[m][t][2] <= $signed(s2_q[t][63:32]) * $signed({1'b0, s2_icq[m][t][23:0]});
          s3_qp[m][t][3] <= $signed(s2_q[t][63:32]) * $signed(s2_icq[m][t][COEF_W-1:24]);
        end
      end

      s4_v    <= s3_v;
      s4_d    <= d_next;
      s4_flag <= flag4_next;
      s4_lin  <= s3_lin;
      s4_term <= term_next;
      s4_ic0  <= s3_ic0;

      s5_d    <= s4_d;
      s5_adj  <= adj_next;
      s5_flag <= flag5_next;
      s5_iacc <= iacc_next;

      s6_d    <= s5_d;
      s6_adj  <= s5_adj;
      s6_img  <= img_next;
      s6_flag <= flag6_next;
    end
  end

  assign result.valid        = s6_vld;
  assign result.x_delta      = s6_d[0];
  assign result.y_delta      = s6_d[1];
  assign result.z_delta      = s6_d[2];
  assign result.adj_x        = s6_adj[0];
  assign result.adj_y        = s6_adj[1];
  assign result.adj_z        = s6_adj[2];
  assign result.line_delta   = s6_img[0];
  assign result.sample_delta = s6_img[1];
  assign result.saturated    = s6_flag;

endmodule

### rtl/core/rsm_gic_coef_table.sv
`timescale 1ns / 1ps

module rsm_gic_coef_table (
  input  logic                     clk,
  input  logic                     rst,
  input  rsm_gic_pkg::coef_wr_t    wr,
  output rsm_gic_pkg::coef_array_t coefs
);
  import rsm_gic_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
    end else begin
      for (int i = 0; i < NUM_COEF; i++) begin
        if (wr.en && wr.index == INDEX_W'(i)) begin
          coefs[i] <= wr.value;
        end
      end
    end
  end

endmodule

### rtl/core/rsm_gic_check.sv
`timescale 1ns / 1ps

module rsm_gic_check (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input logic                item_op,
  input logic                result_valid,
  input logic                result_ready,
  input rsm_gic_pkg::delta_t line_delta,
  input logic                saturated
);
  import rsm_gic_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid just after reset");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("request refused while the result register is empty");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_op == OP_EVAL) ##1 result_ready ##1 result_ready
      ##1 result_ready ##1 result_ready ##1 result_ready |=> result_valid)
    else $error("evaluate request did not reach the output in time");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(line_delta) && $stable(saturated))
    else $error("stalled result changed");

endmodule

bind rsm_ground_image_correction rsm_gic_check u_check (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_op      (item.op),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .line_delta   (result.line_delta),
  .saturated    (result.saturated)
);

### test/correction_checker.sv
`timescale 1ns / 1ps

module correction_checker (
  input  logic      clk,
  input  logic      rst,
  rsm_gic_item_if   item,
  rsm_gic_result_if result,
  output int        fails,
  output int        pending
);
  import rsm_gic_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    delta_t x_delta;
    delta_t y_delta;
    delta_t z_delta;
    coord_t adj_x;
    coord_t adj_y;
    coord_t adj_z;
    delta_t line_delta;
    delta_t sample_delta;
    logic   saturated;
  } correction_t;

  coef_t       coef_store [NUM_COEF];
  correction_t expected_corrections [$];

  function automatic wide_t coef_of(int i);
    wide_t w;
    w = wide_t'(coef_store[i]);
    return w;
  endfunction

  function automatic wide_t ground_sum(int off, int a, bit sa, int b, bit sb, int c, bit sc,
                                       int p, wide_t vx, wide_t vy, wide_t vz);
    wide_t acc;
    acc = coef_of(off) <<< COORD_W / 2;
    acc = sa ? acc - coef_of(a) * vx : acc + coef_of(a) * vx;
    acc = sb ? acc - coef_of(b) * vy : acc + coef_of(b) * vy;
    acc = sc ? acc - coef_of(c) * vz : acc + coef_of(c) * vz;
    acc = acc + coef_of(p) * vx + coef_of(p + 1) * vy + coef_of(p + 2) * vz;
    return (acc + (wide_t'(1) <<< 31)) >>> 32;
  endfunction

  function automatic wide_t image_sum(int base, wide_t vx, wide_t vy, wide_t vz);
    wide_t acc;
    acc = coef_of(base) <<< 32;
    acc = acc + ((coef_of(base + 1) * vx) <<< 16) + ((coef_of(base + 2) * vy) <<< 16)
              + ((coef_of(base + 3) * vz) <<< 16);
    acc = acc + coef_of(base + 4) * (vx * vx) + coef_of(base + 5) * (vx * vy)
              + coef_of(base + 6) * (vx * vz) + coef_of(base + 7) * (vy * vy)
              + coef_of(base + 8) * (vy * vz) + coef_of(base + 9) * (vz * vz);
    return (acc + (wide_t'(1) <<< 47)) >>> 48;
  endfunction

  function automatic wide_t clamp(wide_t v, int w, inout logic flag);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    lo = -(wide_t'(1) <<< (w - 1));
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic correction_t predict_correction(coord_t x, coord_t y, coord_t z);
    correction_t r;
    wide_t vx;
    wide_t vy;
    wide_t vz;
    wide_t dx;
    wide_t dy;
    wide_t dz;
    logic flag;
    flag = 1'b0;
    vx = wide_t'(x);
    vy = wide_t'(y);
    vz = wide_t'(z);
    dx = clamp(ground_sum(20, 26, 0, 25, 0, 24, 1, 27, vx, vy, vz), DELTA_W, flag);
    dy = clamp(ground_sum(21, 25, 1, 26, 0, 23, 0, 30, vx, vy, vz), DELTA_W, flag);
    dz = clamp(ground_sum(22, 24, 0, 23, 1, 26, 0, 33, vx, vy, vz), DELTA_W, flag);
    r.x_delta = dx[DELTA_W-1:0];
    r.y_delta = dy[DELTA_W-1:0];
    r.z_delta = dz[DELTA_W-1:0];
    r.adj_x = coord_t'(clamp(vx + dx, COORD_W, flag));
    r.adj_y = coord_t'(clamp(vy + dy, COORD_W, flag));
    r.adj_z = coord_t'(clamp(vz + dz, COORD_W, flag));
    r.line_delta = delta_t'(clamp(image_sum(0, vx, vy, vz), DELTA_W, flag));
    r.sample_delta = delta_t'(clamp(image_sum(10, vx, vy, vz), DELTA_W, flag));
    r.saturated = flag;
    return r;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %0s: got %h, expected %h", $time, field, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
    foreach (coef_store[i]) coef_store[i] = '0;
  end

  always @(posedge clk) begin
    correction_t e;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (expected_corrections.size() == 0) begin
          report("unexpected result", '0, '0);
        end else begin
          e = expected_corrections.pop_front();
          if (result.x_delta !== e.x_delta) begin
            report("x_delta", 64'(result.x_delta), 64'(e.x_delta));
          end
          if (result.y_delta !== e.y_delta) begin
            report("y_delta", 64'(result.y_delta), 64'(e.y_delta));
          end
          if (result.z_delta !== e.z_delta) begin
            report("z_delta", 64'(result.z_delta), 64'(e.z_delta));
          end
          if (result.adj_x !== e.adj_x) report("adj_x", 64'(result.adj_x), 64'(e.adj_x));
          if (result.adj_y !== e.adj_y) report("adj_y", 64'(result.adj_y), 64'(e.adj_y));
          if (result.adj_z !== e.adj_z) report("adj_z", 64'(result.adj_z), 64'(e.adj_z));
          if (result.line_delta !== e.line_delta) begin
            report("line_delta", 64'(result.line_delta), 64'(e.line_delta));
          end
          if (result.sample_delta !== e.sample_delta) begin
            report("sample_delta", 64'(result.sample_delta), 64'(e.sample_delta));
          end
          if (result.saturated !== e.saturated) begin
            report("saturated", 64'(result.saturated), 64'(e.saturated));
          end
        end
      end
      if (item.valid && item.ready) begin
        if (item.op == OP_EVAL) begin
          expected_corrections.insert(expected_corrections.size(),
            predict_correction(item.x_coord, item.y_coord, item.z_coord));
        end else if (item.coef_index < NUM_COEF) begin
          coef_store[item.coef_index] = item.coef_value;
        end
      end
    end
    pending = expected_corrections.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rsm_gic_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_LIMIT   = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   busy = 1'b0;
  int   fails;
  int   pending;
  int   idle_cycles = 0;

  rsm_gic_item_if   item_ch ();
  rsm_gic_result_if result_ch ();

  rsm_ground_image_correction dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  correction_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .fails   (fails),
    .pending (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] random_value(int w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 63'(0)} >>> (64 - w);
      1: v = ~({1'b1, 63'(0)} >>> (64 - w));
      2: v = '0;
      3: v = v;
      default: v = $signed(v) >>> (64 - w + $urandom_range(4, 24));
    endcase
    return v;
  endfunction

  task automatic send(logic op, index_t idx, coef_t val, coord_t x, coord_t y, coord_t z);
    int gap;
    gap = busy ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.op <= op;
    item_ch.coef_index <= idx;
    item_ch.coef_value <= val;
    item_ch.x_coord <= x;
    item_ch.y_coord <= y;
    item_ch.z_coord <= z;
    item_ch.valid <= 1'b1;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load(int idx, coef_t val);
    send(OP_LOAD, index_t'(idx), val, coord_t'($urandom), coord_t'($urandom),
         coord_t'($urandom));
  endtask

  task automatic evaluate(coord_t x, coord_t y, coord_t z);
    send(OP_EVAL, index_t'($urandom), coef_t'({$urandom, $urandom}), x, y, z);
  endtask

  initial begin
    int gap;
    result_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      gap = busy ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  initial begin
    coord_t cmax;
    coord_t cmin;
    int waited;
    cmax = {1'b0, {(COORD_W-1){1'b1}}};
    cmin = {1'b1, {(COORD_W-1){1'b0}}};
    item_ch.valid = 1'b0;
    item_ch.op = OP_LOAD;
    item_ch.coef_index = '0;
    item_ch.coef_value = '0;
    item_ch.x_coord = '0;
    item_ch.y_coord = '0;
    item_ch.z_coord = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // With an empty table every correction is zero and the point passes through.
    evaluate(cmax, cmin, '0);
    load(26, coef_t'(64'sd1 <<< 32));
    load(24, coef_t'(-(64'sd1 <<< 32)));
    evaluate(cmax, cmin, 32'sd65536);
    load(0, {1'b0, {(COEF_W-1){1'b1}}});
    load(20, {1'b1, {(COEF_W-1){1'b0}}});
    load(NUM_COEF, {1'b0, {(COEF_W-1){1'b1}}});
    load(63, {1'b0, {(COEF_W-1){1'b1}}});
    evaluate(cmin, cmax, cmax);
    evaluate(cmax, cmax, cmin);
    load(4, coef_t'(64'sd1 <<< 32));
    load(19, {1'b1, {(COEF_W-1){1'b0}}});
    load(35, coef_t'(64'sd3 <<< 30));
    evaluate(cmin, cmin, cmin);
    evaluate(32'sd1, -32'sd1, 32'sd32768);
    evaluate(-32'sd32768, 32'sd0, 32'sd1);
    for (int i = 0; i < NUM_COEF; i++) load(i, '0);
    evaluate(cmax, cmax, cmax);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      busy = (n >= 300 && n < 450);
      if (n == 700) begin
        waited = 0;
        while (pending != 0 && waited < IDLE_LIMIT) begin
          @(negedge clk);
          waited++;
        end
      end
      if ($urandom_range(0, 9) < 3) begin
        load($urandom_range(0, 9) == 0 ? $urandom_range(NUM_COEF, 63)
                                       : $urandom_range(0, NUM_COEF - 1),
             coef_t'(random_value(COEF_W)));
      end else begin
        evaluate(coord_t'(random_value(COORD_W)), coord_t'(random_value(COORD_W)),
                 coord_t'(random_value(COORD_W)));
      end
    end
    busy = 1'b0;
    item_ch.valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < IDLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
